// File: src/gtg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtg_pkg
// shared constants and types for the go-to-goal drive command pipeline
// ----------------------------------------------------------------------------
package gtg_pkg;

    localparam int TABLE_LEN = 24;

    // atan(2^-i) in binary angle units, 2^32 per turn
    localparam logic [31:0] ATAN_TABLE [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    localparam logic [31:0] HALF_TURN    = 32'h80000000;
    localparam logic [31:0] ANG_ROUND    = 32'h00008000;
    localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
    localparam logic [15:0] ROUND_Q16    = 16'h8000;
    localparam logic [23:0] SPEED_MAX    = 24'hFFFFFF;

    localparam logic [23:0] ARRIVE_RST   = 24'd307;
    localparam logic [15:0] GAIN_RST     = 16'd50412;
    localparam logic [14:0] MAX_TURN_RST = 15'd5461;

    typedef enum logic [1:0] {
        REG_ARRIVE = 2'd0,
        REG_GAIN   = 2'd1,
        REG_MAXT   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic en;
        logic vld;
    } t_pipe_ctl;

endpackage

// File: src/gtg_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtg_cordic
// pipelined cordic vectoring: half-turn pre-rotation then one stage per
// iteration, accumulating the angle on top of the incoming seed
// ----------------------------------------------------------------------------
module gtg_cordic
    import gtg_pkg::*;
#(
    parameter int POS_WIDTH = 24,
    parameter int STAGES    = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_pipe_ctl                 i_ctl,
    input  logic signed [POS_WIDTH:0] i_dx,
    input  logic signed [POS_WIDTH:0] i_dy,
    input  logic [31:0]               i_ang,
    output logic                      o_vld,
    output logic signed [POS_WIDTH+3:0] o_x,
    output logic [31:0]               o_ang
);

    localparam int W = POS_WIDTH + 4;

    logic                r_vld [STAGES+1];
    logic signed [W-1:0] r_x   [STAGES+1];
    logic signed [W-1:0] r_y   [STAGES+1];
    logic [31:0]         r_ang [STAGES+1];

    logic signed [W-1:0] w_xe;
    logic signed [W-1:0] w_ye;

    assign w_xe = {{3{i_dx[POS_WIDTH]}}, i_dx};
    assign w_ye = {{3{i_dy[POS_WIDTH]}}, i_dy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld[0] <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (w_xe < 0) begin
                r_x[0]   <= -w_xe;
                r_y[0]   <= -w_ye;
                r_ang[0] <= i_ang + HALF_TURN;
            end else begin
                r_x[0]   <= w_xe;
                r_y[0]   <= w_ye;
                r_ang[0] <= i_ang;
            end
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic signed [W-1:0] w_xs;
        logic signed [W-1:0] w_ys;

        assign w_xs = r_x[g] >>> g;
        assign w_ys = r_y[g] >>> g;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                if (r_y[g] > 0) begin
                    r_x[g+1]   <= r_x[g] + w_ys;
                    r_y[g+1]   <= r_y[g] - w_xs;
                    r_ang[g+1] <= r_ang[g] + ATAN_TABLE[g];
                end else begin
                    r_x[g+1]   <= r_x[g] - w_ys;
                    r_y[g+1]   <= r_y[g] + w_xs;
                    r_ang[g+1] <= r_ang[g] - ATAN_TABLE[g];
                end
            end
        end
    end

    assign o_vld = r_vld[STAGES];
    assign o_x   = r_x[STAGES];
    assign o_ang = r_ang[STAGES];

endmodule

// File: src/go_to_goal_drive_command.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_to_goal_drive_command
// pose and goal in, speed and turn command out, via a pipelined cordic
//
// channel   dir   fields (low bit first)
// s_axis    in    cur_x, cur_y, cur_heading, goal_x, goal_y
// m_axis    out   speed_cmd, turn_cmd; tuser: arrived
// apb       in    arrive_threshold @0x0, speed_gain @0x4, max_turn @0x8
//
// one word per cycle while the output is not stalled; stages are the offset
// stage, pre-rotation, CORDIC_STAGES cordic stages, two multiplier and output stages
// synchronous active-low reset clears valid bits and loads the config registers with their reset values
// the whole pipeline holds while the output word is stalled
// ----------------------------------------------------------------------------
module go_to_goal_drive_command
    import gtg_pkg::*;
#(
    parameter int CORDIC_STAGES = 16,
    parameter int POS_WIDTH     = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // cur_x, cur_y, cur_heading, goal_x, goal_y, zero fill
    input  logic [((4*POS_WIDTH+16+7)/8)*8-1:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // speed_cmd, turn_cmd
    output logic [39:0] m_axis_tdata,
    // arrived
    output logic [0:0]  m_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int P  = POS_WIDTH;
    localparam int W  = P + 4;
    localparam int DW = P + 3;
    localparam int SW = (DW > 24) ? DW : 24;

    logic        w_en;
    t_pipe_ctl   w_ctl;
    t_reg_idx    w_idx;

    logic [23:0] r_thr;
    logic [15:0] r_gain;
    logic [14:0] r_maxt;

    logic signed [P-1:0] w_cur_x, w_cur_y, w_goal_x, w_goal_y;
    logic [15:0]         w_hd;

    logic                r_s0_vld;
    logic signed [P:0]   r_s0_dx, r_s0_dy;
    logic [31:0]         r_s0_ang;

    logic                w_c_vld;
    logic signed [W-1:0] w_c_x;
    logic [31:0]         w_c_ang;

    logic                r_m1_vld;
    logic [DW+15:0]      r_m1_prod;
    logic [31:0]         r_m1_ang;
    logic [DW-1:0]       w_xu;

    logic                r_m2_vld;
    logic                r_m2_arr;
    logic [DW-1:0]       r_m2_sp;
    logic [15:0]         r_m2_turn;
    logic [DW-1:0]       w_dist;
    logic [DW+15:0]      w_sprod;
    logic [31:0]         w_b;
    logic signed [15:0]  w_d;
    logic signed [16:0]  w_d17, w_lim, w_turn;

    logic                r_out_vld;
    logic [39:0]         r_out_data;
    logic                r_out_arr;
    logic [SW-1:0]       w_sp_ext;
    logic [23:0]         w_speed;

    // configuration port
    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= ARRIVE_RST;
            r_gain <= GAIN_RST;
            r_maxt <= MAX_TURN_RST;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_ARRIVE: r_thr  <= pwdata[23:0];
                REG_GAIN:   r_gain <= pwdata[15:0];
                REG_MAXT:   r_maxt <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ARRIVE: prdata = {8'd0, r_thr};
            REG_GAIN:   prdata = {16'd0, r_gain};
            REG_MAXT:   prdata = {17'd0, r_maxt};
            default:    prdata = 32'd0;
        endcase
    end

    // pipeline enable
    assign w_en          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en;

    assign w_cur_x  = s_axis_tdata[P-1:0];
    assign w_cur_y  = s_axis_tdata[2*P-1:P];
    assign w_hd     = s_axis_tdata[2*P+15:2*P];
    assign w_goal_x = s_axis_tdata[3*P+15:2*P+16];
    assign w_goal_y = s_axis_tdata[4*P+15:3*P+16];

    // offset stage; the angle seed is minus heading so the cordic output
    // is already the bearing error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_en) begin
            r_s0_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_dx  <= {w_goal_x[P-1], w_goal_x} - {w_cur_x[P-1], w_cur_x};
            r_s0_dy  <= {w_goal_y[P-1], w_goal_y} - {w_cur_y[P-1], w_cur_y};
            r_s0_ang <= 32'd0 - {w_hd, 16'd0};
        end
    end

    assign w_ctl.en  = w_en;
    assign w_ctl.vld = r_s0_vld;

    gtg_cordic #(
        .POS_WIDTH (POS_WIDTH),
        .STAGES    (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_dx    (r_s0_dx),
        .i_dy    (r_s0_dy),
        .i_ang   (r_s0_ang),
        .o_vld   (w_c_vld),
        .o_x     (w_c_x),
        .o_ang   (w_c_ang)
    );

    // gain correction
    assign w_xu = w_c_x[W-1] ? '0 : w_c_x[W-2:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
        end else if (w_en) begin
            r_m1_vld <= w_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_prod <= (DW+16)'(w_xu) * (DW+16)'(INV_GAIN_Q16) + (DW+16)'(ROUND_Q16);
            r_m1_ang  <= w_c_ang;
        end
    end

    // speed product, arrival compare, turn clamp
    assign w_dist  = r_m1_prod[DW+15:16];
    assign w_sprod = (DW+16)'(w_dist) * (DW+16)'(r_gain);
    assign w_b     = r_m1_ang + ANG_ROUND;
    assign w_d     = w_b[31:16];
    assign w_d17   = {w_d[15], w_d};
    assign w_lim   = {2'b00, r_maxt};

    always_comb begin
        if (w_d == 16'sh8000) begin
            w_turn = w_lim;
        end else if (w_d17 > w_lim) begin
            w_turn = w_lim;
        end else if (w_d17 < -w_lim) begin
            w_turn = -w_lim;
        end else begin
            w_turn = w_d17;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_vld <= 1'b0;
        end else if (w_en) begin
            r_m2_vld <= r_m1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m2_arr  <= SW'(w_dist) <= SW'(r_thr);
            r_m2_sp   <= w_sprod[DW+15:16];
            r_m2_turn <= w_turn[15:0];
        end
    end

    // saturation and output register
    assign w_sp_ext = SW'(r_m2_sp);
    assign w_speed  = (w_sp_ext > SW'(SPEED_MAX)) ? SPEED_MAX : w_sp_ext[23:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_m2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_arr  <= r_m2_arr;
            r_out_data <= r_m2_arr ? 40'd0 : {r_m2_turn, w_speed};
        end
    end

    assign m_axis_tvalid   = r_out_vld;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_arr;

    // checks
    a_arrived_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 40'd0))
        else $error("arrived word carries nonzero command");

    a_turn_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[39:24] != 16'h8000))
        else $error("turn command reached minus half turn");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_m2_sp) && $stable(r_m2_vld) && $stable(r_m1_prod)))
        else $error("pipeline moved during output stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && !r_m2_vld && !r_s0_vld))
        else $error("valid bits set after reset");

endmodule

// File: verif/tb_go_to_goal_drive_command.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_go_to_goal_drive_command
// self-checking bench for the go-to-goal drive command pipeline: a queue-fed
// driver offers pose words with random gaps, a monitor stalls the output at
// random and compares every command word against a cordic range/bearing
// predictor kept in step with the apb register writes
// ----------------------------------------------------------------------------
module tb_go_to_goal_drive_command
    import gtg_pkg::*;
();

    localparam int STAGES      = 16;
    localparam int LATENCY     = STAGES + 5;
    localparam int REG_SPARE   = 3;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam longint POS_MIN = -64'sd8388608;
    localparam longint POS_MAX = 64'sd8388607;

    // atan(2^-i), 2^32 per turn
    localparam logic [31:0] ATAN_LUT [STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    typedef struct packed {
        logic signed [23:0] goal_y;
        logic signed [23:0] goal_x;
        logic signed [15:0] heading;
        logic signed [23:0] cur_y;
        logic signed [23:0] cur_x;
    } t_pose;

    typedef struct packed {
        logic [23:0]        speed;
        logic signed [15:0] turn;
        logic               arrived;
    } t_drive_cmd;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    // cur_x, cur_y, cur_heading, goal_x, goal_y
    logic [111:0] s_axis_tdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // speed_cmd, turn_cmd
    logic [39:0]  m_axis_tdata;
    // arrived
    logic [0:0]   m_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    // register copies
    logic [23:0] thr_cfg  = 24'd307;
    logic [15:0] gain_cfg = 16'd50412;
    logic [14:0] maxt_cfg = 15'd5461;

    t_pose      pose_q[$];
    t_drive_cmd cmd_q[$];
    t_pose      tx_pose;
    t_drive_cmd want;
    int         send_pct = 0;
    int         recv_pct = 0;
    int         send_gap = 0;
    int         recv_gap = 0;
    int         hold_left = 0;
    bit         hold_req = 1'b0;
    int         err_cnt = 0;
    int         idle_cycles = 0;

    go_to_goal_drive_command u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // range (scaled by 1/K, rounded) and 16-bit bearing of an offset
    function automatic void cordic_polar(input longint dx, input longint dy,
                                         output longint rng, output logic [15:0] brg);
        longint      x, y, xs, ys;
        logic [31:0] ang;
        logic [32:0] rnd;
        x = dx;
        y = dy;
        ang = 32'h0;
        if (x < 0) begin
            x = -x;
            y = -y;
            ang = 32'h8000_0000;
        end
        for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                ang = ang + ATAN_LUT[i];
            end else begin
                x = x - ys;
                y = y + xs;
                ang = ang - ATAN_LUT[i];
            end
        end
        if (x < 0)
            x = 0;
        rng = (x * 39797 + 32768) >>> 16;
        rnd = {1'b0, ang} + 33'h0_0000_8000;
        brg = rnd[31:16];
    endfunction

    function automatic t_drive_cmd predict_drive(t_pose p);
        longint      rng, spd;
        logic [15:0] brg, err;
        int          turn, lim;
        t_drive_cmd  c;
        c = '0;
        cordic_polar(longint'(p.goal_x) - longint'(p.cur_x),
                     longint'(p.goal_y) - longint'(p.cur_y), rng, brg);
        if (rng <= longint'(thr_cfg)) begin
            c.arrived = 1'b1;
            return c;
        end
        spd = (rng * longint'(gain_cfg)) >>> 16;
        if (spd > 64'sd16777215)
            spd = 64'sd16777215;
        err = brg - p.heading;
        turn = int'($signed(err));
        // half turn of error counts as +pi
        if (turn == -32768)
            turn = 32768;
        lim = int'(maxt_cfg);
        if (turn > lim)
            turn = lim;
        else if (turn < -lim)
            turn = -lim;
        c.speed = spd[23:0];
        c.turn = turn[15:0];
        return c;
    endfunction

    function automatic logic signed [23:0] fit_pos(longint v);
        if (v < POS_MIN)
            return POS_MIN[23:0];
        if (v > POS_MAX)
            return POS_MAX[23:0];
        return v[23:0];
    endfunction

    function automatic t_pose rand_pose();
        t_pose       p;
        longint      cx, cy, dx, dy, reach, rng;
        logic [15:0] brg;
        int          kind, mag, ofs;
        kind = $urandom_range(0, 99);
        p.cur_x = 24'($urandom);
        p.cur_y = 24'($urandom);
        p.heading = 16'($urandom);
        p.goal_x = 24'($urandom);
        p.goal_y = 24'($urandom);
        cx = p.cur_x;
        cy = p.cur_y;
        if (kind < 35)
            return p;
        if (kind < 45) begin
            if ($urandom_range(0, 1))
                p.goal_x = p.cur_x;
            else
                p.goal_y = p.cur_y;
            return p;
        end
        if (kind < 70) begin
            // around the arrival threshold
            reach = longint'(thr_cfg) + (longint'(thr_cfg) >> 2) + 8;
            dx = longint'($urandom_range(0, 2 * reach)) - reach;
            dy = longint'($urandom_range(0, 2 * reach)) - reach;
        end else begin
            mag = $urandom_range(0, 24);
            dx = longint'($urandom_range(0, 2 << mag)) - (1 << mag);
            mag = $urandom_range(0, 24);
            dy = longint'($urandom_range(0, 2 << mag)) - (1 << mag);
        end
        p.goal_x = fit_pos(cx + dx);
        p.goal_y = fit_pos(cy + dy);
        if (kind >= 90) begin
            // heading chosen so the error lands on the clamp edge
            cordic_polar(longint'(p.goal_x) - cx, longint'(p.goal_y) - cy, rng, brg);
            ofs = int'(maxt_cfg) + $urandom_range(0, 4) - 2;
            if ($urandom_range(0, 1))
                ofs = -ofs;
            p.heading = brg - 16'(ofs);
        end
        return p;
    endfunction

    function automatic int pick_gap(int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_reg_value(logic [31:0] rst_val);
        case ($urandom_range(0, 4))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return rst_val;
            3: return $urandom;
            default: return $urandom >> $urandom_range(8, 31);
        endcase
    endfunction

    task automatic offer_pose(longint cx, longint cy, longint gx, longint gy,
                              logic [15:0] hd);
        t_pose p;
        p.cur_x = cx[23:0];
        p.cur_y = cy[23:0];
        p.heading = hd;
        p.goal_x = gx[23:0];
        p.goal_y = gy[23:0];
        pose_q.push_back(p);
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        while (pose_q.size() != 0 || s_axis_tvalid || cmd_q.size() != 0)
            @(negedge i_clk);
    endtask

    // apb write, then read back through the same port except for the spare index
    task automatic write_reg(int idx, logic [31:0] val);
        logic [31:0] masked;
        case (idx)
            REG_ARRIVE: masked = val & 32'h00FF_FFFF;
            REG_GAIN:   masked = val & 32'h0000_FFFF;
            REG_MAXT:   masked = val & 32'h0000_7FFF;
            default:    masked = 32'h0;
        endcase
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(idx * 4);
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ARRIVE: thr_cfg = masked[23:0];
            REG_GAIN:   gain_cfg = masked[15:0];
            REG_MAXT:   maxt_cfg = masked[14:0];
            default: ;
        endcase
        if (idx != REG_SPARE) begin
            @(posedge i_clk);
            psel <= 1'b1;
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            psel <= 1'b0;
            penable <= 1'b0;
            if (prdata !== masked) begin
                $error("register %0d mismatch: expected %0h, got %0h", idx, masked, prdata);
                err_cnt++;
            end
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                cmd_q.push_back(predict_drive(tx_pose));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pose_q.size() != 0) begin
                    tx_pose = pose_q.pop_front();
                    s_axis_tdata <= tx_pose;
                    s_axis_tvalid <= 1'b1;
                    send_gap = pick_gap(send_pct);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (cmd_q.size() == 0) begin
                    $error("unexpected command word: speed_cmd %0d turn_cmd %0d arrived %0b",
                           m_axis_tdata[23:0], $signed(m_axis_tdata[39:24]), m_axis_tuser[0]);
                    err_cnt++;
                end else begin
                    want = cmd_q.pop_front();
                    if (m_axis_tdata[23:0] !== want.speed) begin
                        $error("speed_cmd mismatch: expected %0d, got %0d",
                               want.speed, m_axis_tdata[23:0]);
                        err_cnt++;
                    end
                    if (m_axis_tdata[39:24] !== want.turn) begin
                        $error("turn_cmd mismatch: expected %0d, got %0d",
                               want.turn, $signed(m_axis_tdata[39:24]));
                        err_cnt++;
                    end
                    if (m_axis_tuser[0] !== want.arrived) begin
                        $error("arrived mismatch: expected %0b, got %0b",
                               want.arrived, m_axis_tuser[0]);
                        err_cnt++;
                    end
                end
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                recv_gap = pick_gap(recv_pct);
                m_axis_tready <= (recv_gap == 0);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("go_to_goal_drive_command verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        longint      rng;
        logic [15:0] brg;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings
        send_pct = 30;
        recv_pct = 30;
        offer_pose(0, 0, 0, 0, 16'h0000);
        offer_pose(POS_MIN, POS_MIN, POS_MIN, POS_MIN, 16'h7FFF);
        offer_pose(POS_MIN, POS_MIN, POS_MAX, POS_MAX, 16'h0000);
        offer_pose(POS_MAX, POS_MAX, POS_MIN, POS_MIN, 16'h8000);
        cordic_polar(POS_MIN - POS_MAX, 0, rng, brg);
        offer_pose(POS_MAX, 0, POS_MIN, 0, brg ^ 16'h8000);
        offer_pose(0, 0, 0, 5000, 16'h7FFF);
        offer_pose(0, 0, 0, -5000, 16'h8000);
        offer_pose(0, 0, 100, 100, 16'h0000);
        offer_pose(0, 0, -400, 0, 16'd12345);
        wait_for_drain();

        // extreme settings, upper pwdata bits set to check masking
        write_reg(REG_ARRIVE, 32'hAB00_0000);
        write_reg(REG_GAIN, 32'hFFFF_FFFF);
        write_reg(REG_MAXT, 32'hFFFF_FFFF);
        @(negedge i_clk);
        offer_pose(POS_MIN, POS_MIN, POS_MAX, POS_MAX, 16'h0000);
        offer_pose(0, 0, 1, 0, 16'h0000);
        offer_pose(5, 5, 5, 5, 16'h1234);
        offer_pose(POS_MAX, 0, POS_MIN, 0, brg ^ 16'h8000);
        offer_pose(0, 0, 0, -9000, 16'd20000);
        wait_for_drain();

        // threshold exactly on a range, then one below it
        cordic_polar(3000, -4000, rng, brg);
        write_reg(REG_ARRIVE, 32'(rng));
        write_reg(REG_GAIN, 32'h0);
        write_reg(REG_MAXT, 32'h0);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        @(negedge i_clk);
        offer_pose(0, 0, 3000, -4000, 16'h0000);
        wait_for_drain();
        write_reg(REG_ARRIVE, 32'(rng - 1));
        @(negedge i_clk);
        offer_pose(0, 0, 3000, -4000, 16'h0000);
        wait_for_drain();
        write_reg(REG_ARRIVE, 32'h00FF_FFFF);
        write_reg(REG_GAIN, 32'd50412);
        write_reg(REG_MAXT, 32'd1);
        @(negedge i_clk);
        offer_pose(POS_MIN, POS_MAX, POS_MAX, POS_MIN, 16'h0000);
        offer_pose(POS_MIN, POS_MIN, POS_MAX, POS_MIN, 16'h4000);
        wait_for_drain();

        // random phases
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_ARRIVE, pick_reg_value(32'd307));
            write_reg(REG_GAIN, pick_reg_value(32'd50412));
            write_reg(REG_MAXT, pick_reg_value(32'd5461));
            @(negedge i_clk);
            send_pct = (ph == 1) ? 0 : $urandom_range(5, 60);
            recv_pct = (ph == 1) ? 0 : $urandom_range(5, 60);
            if (ph == 3) begin
                // output held off while the input keeps coming
                send_pct = 0;
                hold_req = 1'b1;
            end
            for (int n = 0; n < 125; n++)
                pose_q.push_back(rand_pose());
            // sender waits for every outstanding command
            wait_for_drain();
            for (int n = 0; n < 125; n++)
                pose_q.push_back(rand_pose());
            wait_for_drain();
        end

        repeat (2 * LATENCY) @(posedge i_clk);
        if (cmd_q.size() != 0) begin
            $error("%0d command words never arrived", cmd_q.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("go_to_goal_drive_command verification clean");
        end else begin
            $display("go_to_goal_drive_command verification failed");
        end
        $finish;
    end

endmodule
